// ----- hw/rtl/tape_bytecode_interpreter_step_assert.svh -----
// Assertion macros used by the tape interpreter execute unit RTL.
`ifndef TAPE_BYTECODE_INTERPRETER_STEP_ASSERT_SVH
`define TAPE_BYTECODE_INTERPRETER_STEP_ASSERT_SVH

`ifndef SYNTHESIS
`define TBIS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tbis assertion failed");
`define TBIS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define TBIS_ASSERT(lbl, clk, rst_n, prop)
`define TBIS_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ----- hw/rtl/tbis_pkg.sv -----
// Shared types and constants of the tape interpreter.
package tbis_pkg;

  localparam int unsigned TapeCells = 32768;
  localparam int unsigned DpW       = $clog2(TapeCells);
  localparam int unsigned PcW       = 17;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    OP_PTR_INC = 3'd0,
    OP_PTR_DEC = 3'd1,
    OP_INC     = 3'd2,
    OP_DEC     = 3'd3,
    OP_PUT     = 3'd4,
    OP_GET     = 3'd5,
    OP_NOP     = 3'd6,
    OP_JUMP    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    CMD_PTR_INC  = 4'd0,
    CMD_PTR_DEC  = 4'd1,
    CMD_INC      = 4'd2,
    CMD_DEC      = 4'd3,
    CMD_PUT      = 4'd4,
    CMD_GET      = 4'd5,
    CMD_NOP      = 4'd6,
    CMD_JMP_FWD  = 4'd7,
    CMD_JMP_BACK = 4'd8
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] target;
    logic [7:0]  in_char;
  } cmd_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        put_valid;
    logic [7:0]  put_char;
    logic        led_level;
    logic        done_res;
  } res_t;

endpackage

// ----- hw/rtl/tape_bytecode_interpreter_step.sv -----
// Top level of the tape machine bytecode interpreter step unit.
//
// Executes one pre-parsed tape-machine instruction per input transaction and
// returns exactly one result transaction for it (next program counter, put
// character/valid, LED level, done flag). Instructions enter a front end that
// classifies them and drops them into a two-entry queue; the execute unit
// pops one command and reads the current tape cell from a synchronous RAM
// into a read register; once the output register is free, it writes the
// modified cell and the updated pointer/counter and returns to idle, so it
// takes no new command until the previous one has finished. The
// result sits in an output register, so the queue keeps taking instructions
// while a result waits. After reset the tape RAM is swept to zero, one cell
// per cycle (all 32768 cells at the default tape size); in_ready_o stays low
// until that is done, while program_last writes on the config port are taken
// at any time. Once the counter passes program_last the unit is halted:
// further instructions return done with the counter held and no side
// effects, until reset.
module tape_bytecode_interpreter_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // instruction channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic        is_back_jump_i,
  input  logic [15:0] jump_target_i,
  input  logic [7:0]  in_char_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic        put_valid_o,
  output logic [7:0]  put_char_o,
  output logic        led_level_o,
  output logic        done_res_o,
  // config write channel (program_last)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i
);

  logic           program_last_q;
  logic [15:0]    program_last_val_q;
  logic           clear_busy;
  logic           q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  tbis_pkg::cmd_t q_in_cmd, q_out_cmd;
  tbis_pkg::res_t res;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_last_val_q <= 16'd0;
      program_last_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      program_last_val_q <= cfg_wdata_i;
      program_last_q     <= 1'b1;
    end
  end

  tbis_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .is_back_jump_i (is_back_jump_i),
    .jump_target_i  (jump_target_i),
    .in_char_i      (in_char_i),
    .clear_busy_i   (clear_busy),
    .q_valid_o      (q_in_valid),
    .q_ready_i      (q_in_ready),
    .q_cmd_o        (q_in_cmd)
  );

  tbis_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_cmd_i   (q_in_cmd),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_cmd_o    (q_out_cmd)
  );

  tbis_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .program_last_i (program_last_q ? program_last_val_q : 16'd0),
    .cmd_valid_i    (q_out_valid),
    .cmd_ready_o    (q_out_ready),
    .cmd_i          (q_out_cmd),
    .clear_busy_o   (clear_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .res_o          (res)
  );

  assign next_pc_o   = res.next_pc;
  assign put_valid_o = res.put_valid;
  assign put_char_o  = res.put_char;
  assign led_level_o = res.led_level;
  assign done_res_o  = res.done_res;

endmodule

// ----- hw/rtl/tbis_front.sv -----
// Front end: accepts instruction transactions and classifies them into commands.
module tbis_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        opcode_i,
  input  logic              is_back_jump_i,
  input  logic [15:0]       jump_target_i,
  input  logic [7:0]        in_char_i,
  input  logic              clear_busy_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output tbis_pkg::cmd_t    q_cmd_o
);

  tbis_pkg::op_e  op;
  tbis_pkg::cmd_e kind;

  assign op = tbis_pkg::op_e'(opcode_i);

  always_comb begin
    case (op)
      tbis_pkg::OP_PTR_INC: kind = tbis_pkg::CMD_PTR_INC;
      tbis_pkg::OP_PTR_DEC: kind = tbis_pkg::CMD_PTR_DEC;
      tbis_pkg::OP_INC:     kind = tbis_pkg::CMD_INC;
      tbis_pkg::OP_DEC:     kind = tbis_pkg::CMD_DEC;
      tbis_pkg::OP_PUT:     kind = tbis_pkg::CMD_PUT;
      tbis_pkg::OP_GET:     kind = tbis_pkg::CMD_GET;
      tbis_pkg::OP_NOP:     kind = tbis_pkg::CMD_NOP;
      tbis_pkg::OP_JUMP: begin
        kind = is_back_jump_i ? tbis_pkg::CMD_JMP_BACK : tbis_pkg::CMD_JMP_FWD;
      end
      default:              kind = tbis_pkg::CMD_NOP;
    endcase
  end

  // no intake while the tape is being cleared
  assign in_ready_o       = q_ready_i && !clear_busy_i;
  assign q_valid_o        = in_valid_i && !clear_busy_i;
  assign q_cmd_o.kind     = kind;
  assign q_cmd_o.target   = jump_target_i;
  assign q_cmd_o.in_char  = in_char_i;

endmodule

// ----- hw/rtl/tbis_queue.sv -----
// Short command queue between front end and execute unit.
module tbis_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tbis_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tbis_pkg::cmd_t pop_cmd_o
);

  localparam logic [tbis_pkg::QPtrW-1:0] PtrLast = tbis_pkg::QPtrW'(tbis_pkg::QDepth - 1);
  localparam logic [tbis_pkg::QCntW-1:0] CntFull = tbis_pkg::QCntW'(tbis_pkg::QDepth);

  tbis_pkg::cmd_t                 slot_q [tbis_pkg::QDepth];
  logic [tbis_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tbis_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + tbis_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + tbis_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + tbis_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - tbis_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hw/rtl/tbis_back.sv -----
// Execute unit: tape memory, machine state and result register.
`include "tape_bytecode_interpreter_step_assert.svh"

module tbis_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    program_last_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  tbis_pkg::cmd_t cmd_i,
  output logic           clear_busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tbis_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } back_state_e;

  localparam logic [tbis_pkg::DpW-1:0] DpLast = tbis_pkg::DpW'(tbis_pkg::TapeCells - 1);

  back_state_e                 state_q, state_d;
  logic [tbis_pkg::DpW-1:0]    clr_addr_q, clr_addr_d;
  logic [tbis_pkg::DpW-1:0]    dp_q, dp_d;
  logic [tbis_pkg::PcW-1:0]    pc_q, pc_d;
  logic                        led_next_q, led_next_d;
  logic                        halted_q, halted_d;
  logic                        out_valid_q, out_valid_d;
  tbis_pkg::cmd_t              cmd_q;
  tbis_pkg::res_t              res_q, res_d;

  logic [7:0]                  tape_mem [tbis_pkg::TapeCells];
  logic [7:0]                  tape_rd_q;

  logic                        pop, exec_fire, out_free, run;
  logic                        mem_re, mem_we, exec_we;
  logic [tbis_pkg::DpW-1:0]    mem_waddr;
  logic [7:0]                  mem_wdata, exec_wdata;
  logic                        put;
  logic [tbis_pkg::PcW-1:0]    pc_new;

  assign cmd_ready_o  = (state_q == ST_IDLE);
  assign clear_busy_o = (state_q == ST_CLEAR);
  assign pop          = cmd_valid_i && cmd_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign exec_fire    = (state_q == ST_EXEC) && out_free;
  assign run          = exec_fire && !halted_q;
  assign mem_re       = pop;

  // instruction semantics on the fetched cell
  always_comb begin
    dp_d       = dp_q;
    pc_new     = pc_q + tbis_pkg::PcW'(1);
    exec_we    = 1'b0;
    exec_wdata = tape_rd_q;
    put        = 1'b0;
    case (cmd_q.kind)
      tbis_pkg::CMD_PTR_INC: dp_d = (dp_q == DpLast) ? '0 : dp_q + tbis_pkg::DpW'(1);
      tbis_pkg::CMD_PTR_DEC: dp_d = (dp_q == '0) ? DpLast : dp_q - tbis_pkg::DpW'(1);
      tbis_pkg::CMD_INC: begin
        exec_we    = 1'b1;
        exec_wdata = tape_rd_q + 8'd1;
      end
      tbis_pkg::CMD_DEC: begin
        exec_we    = 1'b1;
        exec_wdata = tape_rd_q - 8'd1;
      end
      tbis_pkg::CMD_PUT: put = 1'b1;
      tbis_pkg::CMD_GET: begin
        exec_we    = 1'b1;
        exec_wdata = cmd_q.in_char;
      end
      tbis_pkg::CMD_NOP: ;
      tbis_pkg::CMD_JMP_FWD: begin
        pc_new = (tape_rd_q == 8'd0) ?
                 tbis_pkg::PcW'(cmd_q.target) + tbis_pkg::PcW'(3) :
                 pc_q + tbis_pkg::PcW'(3);
      end
      tbis_pkg::CMD_JMP_BACK: begin
        pc_new = (tape_rd_q != 8'd0) ?
                 tbis_pkg::PcW'(cmd_q.target) + tbis_pkg::PcW'(3) :
                 pc_q + tbis_pkg::PcW'(3);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    pc_d        = pc_q;
    led_next_d  = led_next_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + tbis_pkg::DpW'(1);
        if (clr_addr_q == DpLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (run) begin
      pc_d       = pc_new;
      led_next_d = led_next_q ^ put;
      halted_d   = (pc_new > tbis_pkg::PcW'(program_last_i));
    end
    res_d.next_pc   = pc_d[15:0];
    res_d.put_valid = run && put;
    res_d.put_char  = (run && put) ? tape_rd_q : 8'd0;
    res_d.led_level = ~led_next_d;
    res_d.done_res  = halted_d;
  end

  assign mem_we    = clear_busy_o || (run && exec_we);
  assign mem_waddr = clear_busy_o ? clr_addr_q : dp_q;
  assign mem_wdata = clear_busy_o ? 8'd0 : exec_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tape_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      tape_rd_q <= tape_mem[dp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      dp_q        <= '0;
      pc_q        <= '0;
      led_next_q  <= 1'b1;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      dp_q        <= run ? dp_d : dp_q;
      pc_q        <= pc_d;
      led_next_q  <= led_next_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `TBIS_ASSERT(a_halt_sticky, clk_i, rst_ni, halted_q |=> halted_q)
  `TBIS_ASSERT(a_halt_pc_frozen, clk_i, rst_ni, halted_q |=> $stable(pc_q))
  `TBIS_ASSERT_MSG(a_fire_fills_out, clk_i, rst_ni, exec_fire |=> out_valid_q, "result lost")
  `TBIS_ASSERT_MSG(a_led_only_on_put, clk_i, rst_ni,
    !$stable(led_next_q) |-> $past(run && cmd_q.kind == tbis_pkg::CMD_PUT), "stray LED toggle")

endmodule
